FILE: rtl/core/chl_pkg.sv
// Shared types, codes and helper functions of the character-constant lexer.
// No dependencies; every other file of the block imports this package.
package chl_pkg;

  // one input beat, as seen by the lexing logic
  typedef struct packed {
    logic        first;
    logic        wide_literal;
    logic [20:0] code_point;
    logic        end_of_stream;
  } item_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_TERM   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_HEX_EMPTY = 3'd3,
    ST_RANGE     = 3'd4,
    ST_UNK_ESC   = 3'd5,
    ST_MULTI     = 3'd6
  } status_e;

  // one result beat
  typedef struct packed {
    logic [63:0] literal_value;
    logic [15:0] token_length;
    status_e     status;
    logic        consumed_last;
  } result_t;

  localparam logic [20:0] ChNul   = 21'h00;
  localparam logic [20:0] ChLf    = 21'h0A;
  localparam logic [20:0] ChDquot = 21'h22;
  localparam logic [20:0] ChQuote = 21'h27;
  localparam logic [20:0] ChQmark = 21'h3F;
  localparam logic [20:0] ChBsl   = 21'h5C;
  localparam logic [20:0] ChX     = 21'h78;
  localparam logic [20:0] AsciiMax = 21'h7F;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [20:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[21'h30:21'h39]}) r = {1'b1, c[3:0]};
    else if (c inside {[21'h61:21'h66], [21'h41:21'h46]}) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  // {unknown, value}
  function automatic logic [21:0] simple_escape(input logic [20:0] c);
    logic [21:0] r;
    case (c)
      ChDquot, ChQuote, ChQmark, ChBsl: r = {1'b0, c};
      21'h61:  r = {1'b0, 21'h07};  // a
      21'h62:  r = {1'b0, 21'h08};  // b
      21'h66:  r = {1'b0, 21'h0C};  // f
      21'h6E:  r = {1'b0, 21'h0A};  // n
      21'h72:  r = {1'b0, 21'h0D};  // r
      21'h74:  r = {1'b0, 21'h09};  // t
      21'h76:  r = {1'b0, 21'h0B};  // v
      default: r = {1'b1, c};
    endcase
    return r;
  endfunction

  // UTF-8 bytes, lead byte most significant; above 0xFFFF always four bytes
  function automatic logic [31:0] utf8_pack(input logic [20:0] c);
    logic [31:0] r;
    if (c < 21'h800)
      r = {16'h0, 3'b110, c[10:6], 2'b10, c[5:0]};
    else if (c < 21'h10000)
      r = {8'h0, 4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0]};
    else
      r = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]};
    return r;
  endfunction

endpackage

FILE: rtl/core/chl_in_reg.sv
// Input register of the character-constant lexer: one beat of buffering.
// Depends on chl_pkg for the item type.
module chl_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  chl_pkg::item_t item_i,
  input  logic           take_i,   // consumer takes the held beat
  output logic           valid_o,
  output chl_pkg::item_t item_o
);
  import chl_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: rtl/core/chl_step.sv
// Lexer state and per-character update of the character-constant lexer.
// Depends on chl_pkg for item/result types, status codes and char helpers.
module chl_step #(
  parameter int LENGTH_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  chl_pkg::item_t   item_i,
  output logic             emit_o,
  output chl_pkg::result_t result_o
);
  import chl_pkg::*;

  localparam int CntW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_HEX, PH_OCT, PH_AFTER_CHAR, PH_AFTER_ESC, PH_TAIL
  } phase_e;

  phase_e           ph_q, ph_d;
  logic [63:0]      val_q, val_d;
  logic [CntW-1:0]  len_q, len_d, len_out;
  logic             wide_q, wide_d;
  logic             unk_q, unk_d;
  logic             pbs_q, pbs_d;
  status_e          pend_q, pend_d;
  logic             dig_q, dig_d;
  logic             emit;
  status_e          st;
  logic             took, addq;
  logic [20:0]      c;
  logic             eos, lf, quote, over, tail_stop;
  logic [4:0]       hx;
  logic [21:0]      sesc;
  logic [31:0]      u8;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (&v) ? v : v + CntW'(1);
  endfunction

  assign c         = item_i.code_point;
  assign eos       = item_i.end_of_stream;
  assign lf        = !eos && c == ChLf;
  assign quote     = !eos && c == ChQuote;
  assign tail_stop = eos || c == ChNul || c == ChLf;
  assign over      = wide_q ? |val_q[63:31] : |val_q[63:7];
  assign hx        = hex_digit(c);
  assign sesc      = simple_escape(c);
  assign u8        = utf8_pack(c);

  always_comb begin
    ph_d   = ph_q;
    val_d  = val_q;
    len_d  = len_q;
    wide_d = wide_q;
    unk_d  = unk_q;
    pbs_d  = pbs_q;
    pend_d = pend_q;
    dig_d  = dig_q;
    emit   = 1'b0;
    st     = ST_OK;
    took   = 1'b0;
    addq   = 1'b0;
    if (fire_i) begin
      if (item_i.first) begin
        wide_d = item_i.wide_literal;
        val_d  = 64'd0;
        len_d  = {{(CntW-1){1'b0}}, item_i.wide_literal} + CntW'(1);
        unk_d  = 1'b0;
        pbs_d  = 1'b0;
        pend_d = ST_OK;
        dig_d  = 1'b0;
        if (eos || lf) begin
          emit = 1'b1;
          st   = ST_NO_TERM;
        end else if (quote) begin
          emit = 1'b1;
          st   = ST_EMPTY;
          took = 1'b1;
          addq = 1'b1;
        end else begin
          len_d = sat_inc(len_d);
          if (c == ChBsl) begin
            ph_d = PH_ESC;
          end else begin
            val_d = (!item_i.wide_literal && c > AsciiMax) ? {32'd0, u8} : {43'd0, c};
            ph_d  = PH_AFTER_CHAR;
          end
        end
      end else begin
        case (ph_q)
          PH_ESC: begin
            if (eos || lf) begin
              emit = 1'b1;
              st   = ST_NO_TERM;
            end else begin
              len_d = sat_inc(len_q);
              if (c == ChX) begin
                ph_d = PH_HEX;
              end else if (c inside {[21'h30:21'h37]}) begin
                val_d = {61'd0, c[2:0]};
                ph_d  = PH_OCT;
              end else begin
                val_d = {43'd0, sesc[20:0]};
                unk_d = sesc[21];
                ph_d  = PH_AFTER_ESC;
              end
            end
          end
          PH_HEX, PH_OCT, PH_AFTER_CHAR, PH_AFTER_ESC: begin
            if (ph_q == PH_HEX && !eos && hx[4]) begin
              val_d = {val_q[59:0], hx[3:0]};
              len_d = sat_inc(len_q);
              dig_d = 1'b1;
            end else if (ph_q == PH_OCT && !eos && c inside {[21'h30:21'h37]}) begin
              val_d = {val_q[60:0], c[2:0]};
              len_d = sat_inc(len_q);
            end else if (quote) begin
              emit = 1'b1;
              took = 1'b1;
              addq = 1'b1;
              case (ph_q)
                PH_HEX:        st = !dig_q ? ST_HEX_EMPTY : (over ? ST_RANGE : ST_OK);
                PH_OCT:        st = over ? ST_RANGE : ST_OK;
                PH_AFTER_CHAR: st = over ? ST_MULTI : ST_OK;
                default:       st = unk_q ? ST_UNK_ESC : ST_OK;
              endcase
            end else if (tail_stop) begin
              emit = 1'b1;
              st   = ST_NO_TERM;
            end else begin
              // start of a multicharacter tail
              pend_d = (ph_q == PH_HEX && !dig_q) ? ST_HEX_EMPTY : ST_MULTI;
              pbs_d  = (c == ChBsl);
              len_d  = sat_inc(len_q);
              ph_d   = PH_TAIL;
            end
          end
          PH_TAIL: begin
            if (tail_stop) begin
              emit = 1'b1;
              st   = ST_NO_TERM;
            end else if (quote && !pbs_q) begin
              emit = 1'b1;
              st   = pend_q;
              took = 1'b1;
              addq = 1'b1;
            end else begin
              pbs_d = (c == ChBsl);
              len_d = sat_inc(len_q);
            end
          end
          default: ph_d = PH_IDLE;
        endcase
      end
      if (emit) ph_d = PH_IDLE;
    end
  end

  assign len_out                = addq ? sat_inc(len_d) : len_d;
  assign emit_o                 = emit;
  assign result_o.literal_value = val_d;
  assign result_o.token_length  = 16'(len_out);
  assign result_o.status        = st;
  assign result_o.consumed_last = took;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      val_q  <= 64'd0;
      len_q  <= '0;
      wide_q <= 1'b0;
      unk_q  <= 1'b0;
      pbs_q  <= 1'b0;
      pend_q <= ST_OK;
      dig_q  <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      val_q  <= val_d;
      len_q  <= len_d;
      wide_q <= wide_d;
      unk_q  <= unk_d;
      pbs_q  <= pbs_d;
      pend_q <= pend_d;
      dig_q  <= dig_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && emit |=> ph_q == PH_IDLE)
    else $error("phase not idle after a result");

  a_not_taken_is_no_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !took |-> st == ST_NO_TERM)
    else $error("unconsumed final character without missing-terminator status");

  a_hold_without_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(ph_q) && $stable(len_q) && $stable(val_q))
    else $error("lexer state moved without an input beat");

  a_open_token_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.first && !emit |=> len_q >= CntW'(2))
    else $error("open token shorter than quote and one character");
`endif

endmodule

FILE: rtl/core/chl_out_reg.sv
// Result register of the character-constant lexer.
// Depends on chl_pkg for the result type.
module chl_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  chl_pkg::result_t result_i,
  output logic             free_o,   // register can take a result this cycle
  output logic             valid_o,
  input  logic             ready_i,
  output chl_pkg::result_t result_o
);
  import chl_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

endmodule

FILE: rtl/core/char_literal_lexer.sv
// Top level of the character-constant lexer: input register, lexer step, result register.
// Depends on chl_pkg, chl_in_reg, chl_step and chl_out_reg.
//
//  channel | dir | tdata                          | tuser
//  s_axis  | in  | code_point[20:0] (pad to 24)   | first, wide_literal, end_of_stream
//  m_axis  | out | literal_value, token_length    | status[2:0], consumed_last
//
// One character per cycle while the result register can take a result: a beat is
// held in the input register, the lexer step (state update and status decode) works on
// it, and a finished token lands in the result register when the beat is taken.
// Reset clears the lexer to idle and empties both registers; no clearing pass.
// While the result register is full and not being read, the held character
// stalls whether or not it ends a token; the input register holds it and drops tready.
module char_literal_lexer #(
  parameter int LENGTH_BITS = 16   // token length saturates at 2^LENGTH_BITS-1, 65535 at most
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [20:0] code_point, [23:21] zero
  input  logic [2:0]  s_axis_tuser_i,   // [0] first, [1] wide_literal, [2] end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [63:0] literal_value, [79:64] token_length
  output logic [3:0]  m_axis_tuser_o    // [2:0] status, [3] consumed_last
);
  import chl_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid;
  logic    out_free;
  logic    fire;
  logic    emit;
  result_t step_res, out_res;

  // unpack the slave beat into the item record
  assign in_item.first         = s_axis_tuser_i[0];
  assign in_item.wide_literal  = s_axis_tuser_i[1];
  assign in_item.end_of_stream = s_axis_tuser_i[2];
  assign in_item.code_point    = s_axis_tdata_i[20:0];

  // the held beat is worked whenever the result register can take its result
  assign fire = held_valid && out_free;

  chl_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .take_i  (fire),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  chl_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (held_item),
    .emit_o   (emit),
    .result_o (step_res)
  );

  chl_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && emit),
    .result_i (step_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  // pack the master beat
  assign m_axis_tdata_o = {out_res.token_length, out_res.literal_value};
  assign m_axis_tuser_o = {out_res.consumed_last, out_res.status};

endmodule

FILE: dv/tb_char_literal_lexer.sv
`timescale 1ns / 1ps
// Self-checking testbench of char_literal_lexer: directed and random character streams.
// Depends on chl_pkg (item, result and status types, character codes) and the lexer RTL.

module tb_char_literal_lexer;
  import chl_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 10;   // result register lags the last accepted beat

  typedef enum logic [2:0] {
    LX_IDLE, LX_ESC, LX_HEX, LX_OCT, LX_AFTER_CHAR, LX_AFTER_ESC, LX_TAIL
  } lex_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_tdata = '0;         // [20:0] code_point, [23:21] zero
  logic [2:0]  s_tuser = '0;         // [0] first, [1] wide_literal, [2] end_of_stream
  logic        m_axis_tvalid_o;
  logic        m_ready = 1'b0;
  logic [79:0] m_axis_tdata_o;       // [63:0] literal_value, [79:64] token_length
  logic [3:0]  m_axis_tuser_o;       // [2:0] status, [3] consumed_last

  char_literal_lexer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // lexer state as predicted
  lex_phase_e  lx_phase = LX_IDLE;
  logic [63:0] lx_value = '0;
  logic [15:0] lx_len = '0;
  logic        lx_wide = 1'b0;
  logic        lx_unknown = 1'b0;
  logic        lx_shield = 1'b0;     // previous tail character was a backslash
  status_e     lx_pending = ST_OK;   // status a tail will close with
  logic [15:0] lx_digits = '0;

  result_t expected_tokens[$];
  item_t   token_chars[$];
  logic    token_wide = 1'b0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      chars_lexed = 0;          // beats that were not ignored
  int      results_seen = 0;
  int      fail_count = 0;
  int      cycle_count = 0;
  result_t exp_tok;

  // ---------------------------------------------------------------- prediction

  function automatic logic [15:0] len_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit over_range();
    return lx_wide ? (lx_value > 64'h7FFF_FFFF) : (lx_value > 64'h7F);
  endfunction

  function automatic int hex_value(input logic [20:0] c);
    if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
    if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
    if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
    return -1;
  endfunction

  // UTF-8 bytes, lead byte on top
  function automatic logic [63:0] utf8_bytes(input logic [20:0] c);
    if (c < 21'h800)
      return ((64'hC0 | c[10:6]) << 8) | 64'h80 | c[5:0];
    if (c < 21'h10000)
      return ((64'hE0 | c[15:12]) << 16) | ((64'h80 | c[11:6]) << 8) | 64'h80 | c[5:0];
    return ((64'hF0 | c[20:18]) << 24) | ((64'h80 | c[17:12]) << 16)
         | ((64'h80 | c[11:6]) << 8) | 64'h80 | c[5:0];
  endfunction

  function automatic logic [63:0] escape_value(input logic [20:0] c, output logic unknown);
    unknown = 1'b0;
    case (c)
      21'h22, 21'h27, 21'h3F, 21'h5C: return 64'(c);
      21'h61: return 64'h07;   // a
      21'h62: return 64'h08;   // b
      21'h66: return 64'h0C;   // f
      21'h6E: return 64'h0A;   // n
      21'h72: return 64'h0D;   // r
      21'h74: return 64'h09;   // t
      21'h76: return 64'h0B;   // v
      default: begin
        unknown = 1'b1;
        return 64'(c);
      end
    endcase
  endfunction

  function automatic bit token_done(input status_e st, input logic took, input bit closing,
                                    output result_t r);
    r.literal_value = lx_value;
    r.token_length  = closing ? len_inc(lx_len) : lx_len;
    r.status        = st;
    r.consumed_last = took;
    lx_phase = LX_IDLE;
    return 1'b1;
  endfunction

  function automatic bit tail_char(input logic [20:0] c, input logic eos, output result_t r);
    if (eos || c == ChNul || c == ChLf) return token_done(ST_NO_TERM, 1'b0, 1'b0, r);
    if (c == ChQuote && !lx_shield) return token_done(lx_pending, 1'b1, 1'b1, r);
    lx_shield = (c == ChBsl);
    lx_len = len_inc(lx_len);
    return 1'b0;
  endfunction

  function automatic bit start_tail(input status_e code, input logic [20:0] c, input logic eos,
                                    output result_t r);
    lx_pending = code;
    lx_shield = 1'b0;
    lx_phase = LX_TAIL;
    return tail_char(c, eos, r);
  endfunction

  // one accepted beat; returns 1 when a token result is due
  function automatic bit lex_predict(input item_t it, output result_t r);
    logic [20:0] c;
    logic        eos;
    bit          quote;
    int          d;
    logic        unk;
    c = it.code_point;
    eos = it.end_of_stream;
    quote = !eos && c == ChQuote;
    r = '0;
    if (it.first) begin
      // a first beat always restarts, abandoning any token in flight
      chars_lexed++;
      lx_wide = it.wide_literal;
      lx_value = '0;
      lx_len = lx_wide ? 16'd2 : 16'd1;
      lx_unknown = 1'b0;
      lx_shield = 1'b0;
      lx_pending = ST_OK;
      lx_digits = '0;
      if (eos || c == ChLf) return token_done(ST_NO_TERM, 1'b0, 1'b0, r);
      if (c == ChQuote) return token_done(ST_EMPTY, 1'b1, 1'b1, r);
      lx_len = len_inc(lx_len);
      if (c == ChBsl) begin
        lx_phase = LX_ESC;
        return 1'b0;
      end
      lx_value = (!lx_wide && c > AsciiMax) ? utf8_bytes(c) : 64'(c);
      lx_phase = LX_AFTER_CHAR;
      return 1'b0;
    end
    if (lx_phase != LX_IDLE) chars_lexed++;
    case (lx_phase)
      LX_ESC: begin
        if (eos || c == ChLf) return token_done(ST_NO_TERM, 1'b0, 1'b0, r);
        lx_len = len_inc(lx_len);
        if (c == ChX) begin
          lx_phase = LX_HEX;
        end else if (c >= 21'h30 && c <= 21'h37) begin
          lx_value = 64'(c - 21'h30);
          lx_phase = LX_OCT;
        end else begin
          lx_value = escape_value(c, unk);
          lx_unknown = unk;
          lx_phase = LX_AFTER_ESC;
        end
        return 1'b0;
      end
      LX_HEX: begin
        d = eos ? -1 : hex_value(c);
        if (d >= 0) begin
          lx_value = (lx_value << 4) | 64'(d);
          lx_len = len_inc(lx_len);
          if (lx_digits != 16'hFFFF) lx_digits++;
          return 1'b0;
        end
        if (quote)
          return token_done(lx_digits == 0 ? ST_HEX_EMPTY : (over_range() ? ST_RANGE : ST_OK),
                            1'b1, 1'b1, r);
        return start_tail(lx_digits == 0 ? ST_HEX_EMPTY : ST_MULTI, c, eos, r);
      end
      LX_OCT: begin
        if (!eos && c >= 21'h30 && c <= 21'h37) begin
          lx_value = (lx_value << 3) | 64'(c - 21'h30);
          lx_len = len_inc(lx_len);
          return 1'b0;
        end
        if (quote) return token_done(over_range() ? ST_RANGE : ST_OK, 1'b1, 1'b1, r);
        return start_tail(ST_MULTI, c, eos, r);
      end
      LX_AFTER_CHAR: begin
        if (quote) return token_done(over_range() ? ST_MULTI : ST_OK, 1'b1, 1'b1, r);
        return start_tail(ST_MULTI, c, eos, r);
      end
      LX_AFTER_ESC: begin
        if (quote) return token_done(lx_unknown ? ST_UNK_ESC : ST_OK, 1'b1, 1'b1, r);
        return start_tail(ST_MULTI, c, eos, r);
      end
      LX_TAIL: return tail_char(c, eos, r);
      default: begin
        lx_phase = LX_IDLE;   // stray beat while idle: ignored
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_char(input logic [20:0] cp, input logic is_first = 1'b0,
                                   input logic eos = 1'b0);
    item_t it;
    it.first = is_first;
    it.wide_literal = is_first ? token_wide : 1'($urandom_range(1));
    it.code_point = cp;
    it.end_of_stream = eos;
    token_chars.push_back(it);
  endfunction

  function automatic logic [20:0] any_char();
    case ($urandom_range(9))
      0, 1, 2: return 21'(21'h20 + $urandom_range(94));
      3: begin
        case ($urandom_range(7))
          0: return ChQuote;
          1: return ChBsl;
          2: return ChLf;
          3: return ChNul;
          4: return ChX;
          5: return 21'(21'h30 + $urandom_range(9));
          6: return 21'(21'h41 + $urandom_range(6));
          default: return 21'(21'h61 + $urandom_range(6));
        endcase
      end
      4: return 21'($urandom_range(21'h7F));
      5: return 21'($urandom_range(21'h7FF, 21'h80));
      6: return 21'($urandom_range(21'hFFFF, 21'h800));
      7: return 21'($urandom_range(21'h10FFFF, 21'h10000));
      8: return 21'($urandom_range(21'h1FFFFF));
      default: return 21'(21'h1FFFFF - $urandom_range(3));
    endcase
  endfunction

  function automatic logic [20:0] escape_char();
    case ($urandom_range(12))
      0: return 21'h22;
      1: return ChQuote;
      2: return ChQmark;
      3: return ChBsl;
      4: return 21'h61;
      5: return 21'h62;
      6: return 21'h66;
      7: return 21'h6E;
      8: return 21'h72;
      9: return 21'h74;
      10: return 21'h76;
      default: return any_char();
    endcase
  endfunction

  function automatic logic [20:0] hex_char();
    case ($urandom_range(2))
      0: return 21'(21'h30 + $urandom_range(9));
      1: return 21'(21'h61 + $urandom_range(5));
      default: return 21'(21'h41 + $urandom_range(5));
    endcase
  endfunction

  // mostly well-formed constants with random content; the rest broken or noisy
  function automatic void make_token();
    logic [20:0] c;
    token_wide = 1'($urandom_range(1));
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(3, 1)) add_char(any_char());
    case ($urandom_range(9))
      0, 1, 2: begin
        c = any_char();
        if (c == ChQuote || c == ChBsl || c == ChLf) c = 21'h41;
        add_char(c, 1'b1);
      end
      3, 4: begin
        add_char(ChBsl, 1'b1);
        add_char(escape_char());
      end
      5: begin
        add_char(ChBsl, 1'b1);
        add_char(ChX);
        repeat ($urandom_range(18)) add_char(hex_char());
      end
      6: begin
        add_char(ChBsl, 1'b1);
        repeat ($urandom_range(24, 1)) add_char(21'(21'h30 + $urandom_range(7)));
      end
      7: begin
        add_char(ChQuote, 1'b1);
        return;
      end
      8: add_char(any_char(), 1'b1, 1'($urandom_range(1)));
      default: add_char(ChBsl, 1'b1);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: add_char(ChQuote);
      6, 7: begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(3) == 0) begin
            add_char(ChBsl);
            add_char(ChQuote);
          end else begin
            c = any_char();
            if (c == ChQuote || c == ChLf || c == ChNul) c = 21'h7A;
            add_char(c);
          end
        end
        add_char(ChQuote);
      end
      8: begin
        case ($urandom_range(2))
          0: add_char(any_char(), 1'b0, 1'b1);
          1: add_char(ChLf);
          default: add_char(ChNul);
        endcase
      end
      default: ;   // left open: the next first beat abandons it
    endcase
  endfunction

  // called in the time step of a rising edge; returns in the step of the accepting edge
  task automatic send_char(input item_t it);
    result_t r;
    while ($urandom_range(99) < gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {3'b000, it.code_point};
    s_tuser <= {it.end_of_stream, it.wide_literal, it.first};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    if (lex_predict(it, r)) expected_tokens.push_back(r);
    @(posedge clk_i);
  endtask

  task automatic send_token();
    foreach (token_chars[i]) send_char(token_chars[i]);
    token_chars.delete();
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) m_ready <= rst_ni && ($urandom_range(99) >= stall_pct);

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // sampled mid-cycle, where every input and output is settled
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      results_seen++;
      if (expected_tokens.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with none expected, got value %h length %h tuser %h",
                 $time, m_axis_tdata_o[63:0], m_axis_tdata_o[79:64], m_axis_tuser_o);
      end else begin
        exp_tok = expected_tokens.pop_front();
        check_field("literal_value", exp_tok.literal_value, m_axis_tdata_o[63:0]);
        check_field("token_length", 64'(exp_tok.token_length), 64'(m_axis_tdata_o[79:64]));
        check_field("status", 64'(exp_tok.status), 64'(m_axis_tuser_o[2:0]));
        check_field("consumed_last", 64'(exp_tok.consumed_last), 64'(m_axis_tuser_o[3]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_tokens.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_tokens();
    token_wide = 1'b0;
    add_char(ChNul, 1'b1, 1'b1);                       // stream ends after the quote
    add_char(ChQuote, 1'b1);                           // empty constant
    add_char(21'h61, 1'b1); add_char(ChQuote);
    add_char(21'h1FFFFF, 1'b1); add_char(ChQuote);     // narrow, four UTF-8 bytes
    add_char(21'h61);                                  // stray beat while idle
    add_char(ChBsl, 1'b1); add_char(21'h71); add_char(ChQuote);   // unknown escape
    add_char(ChBsl, 1'b1); add_char(ChX); add_char(ChQuote);      // hex without digits
    add_char(ChBsl, 1'b1); add_char(ChX); add_char(21'h46); add_char(21'h66);
    add_char(ChQuote);                                 // over the narrow range
    add_char(ChBsl, 1'b1); add_char(21'h37); add_char(ChQuote);
    add_char(21'h61, 1'b1); add_char(ChBsl); add_char(ChQuote);
    add_char(ChQuote);                                 // shielded quote in the tail
    add_char(ChBsl, 1'b1); add_char(ChLf);             // line ends after the backslash
    add_char(21'h61, 1'b1); add_char(21'h62, 1'b1);    // restart mid-token
    add_char(ChQuote);
    token_wide = 1'b1;
    add_char(21'h10FFFF, 1'b1); add_char(ChQuote);
    send_token();
  endtask

  // long wide multicharacter tail, sent back to back
  task automatic test_long_tail();
    item_t it;
    it.first = 1'b1;
    it.wide_literal = 1'b1;
    it.code_point = 21'h61;
    it.end_of_stream = 1'b0;
    send_char(it);
    it.first = 1'b0;
    it.code_point = 21'h62;
    repeat (40) send_char(it);
    it.code_point = ChQuote;
    send_char(it);
  endtask

  task automatic test_random_tokens(input int gap, input int stall, input int quota);
    int target;
    gap_pct = gap;
    stall_pct = stall;
    target = chars_lexed + quota;
    while (chars_lexed < target) begin
      make_token();
      send_token();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_tokens();
    test_long_tail();
    test_random_tokens(0, 0, 190);
    test_random_tokens(62, 0, 190);
    test_random_tokens(0, 62, 190);
    test_random_tokens(33, 33, 190);
    s_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Lexed %0d characters into %0d token results over %0d cycles;",
             chars_lexed, results_seen, cycle_count);
    $display("directed tokens, a long tail and four idling mixes, %0d mismatches.",
             fail_count);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
